### rtl/lpmd_pkg.sv
// shared types, codes and helpers of the length-prefixed message deframer
`timescale 1ns / 1ps
`default_nettype none

package lpmd_pkg;

  localparam int unsigned HeaderBytes = 6;
  localparam int unsigned PlenBytes   = 4;

  typedef enum logic [2:0] {
    PH_LEN_HI  = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_IDENT   = 3'd2,
    PH_PLEN    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DONE    = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_IDENT   = 2'd1,
    KIND_PAYLOAD = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    VERDICT_OK       = 2'd0,
    VERDICT_BADCHAR  = 2'd1,
    VERDICT_MISMATCH = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      byte_kind;
    logic       frame_end;
    verdict_e   verdict;
  } result_t;

  // digits, upper and lower case letters, underscore
  function automatic logic allowed_char(input logic [7:0] c);
    allowed_char = (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd90) ||
                   (c >= 8'd97 && c <= 8'd122) || (c == 8'd95);
  endfunction

endpackage

`default_nettype wire

### rtl/lpmd_in_if.sv
// input byte channel of the deframer
`timescale 1ns / 1ps
`default_nettype none

interface lpmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, in_byte, in_last, input ready);
  modport sink (input valid, in_byte, in_last, output ready);
endinterface

`default_nettype wire

### rtl/lpmd_out_if.sv
// tagged result channel of the deframer
`timescale 1ns / 1ps
`default_nettype none

interface lpmd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] byte_kind;
  logic       frame_end;
  logic [1:0] verdict;

  modport source (output valid, out_byte, byte_kind, frame_end, verdict, input ready);
  modport sink (input valid, out_byte, byte_kind, frame_end, verdict, output ready);
endinterface

`default_nettype wire

### rtl/lpmd_parser.sv
// packet layout parser: phase, length and count registers plus byte tagging
`timescale 1ns / 1ps
`default_nettype none

module lpmd_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       byte_i,
  input  wire logic             last_i,
  output lpmd_pkg::result_t     result_o
);

  lpmd_pkg::phase_e phase_q, phase_d;
  logic [15:0] ident_len_q, ident_len_d;
  logic [31:0] plen_q, plen_d;
  logic [31:0] count_q, count_d;
  logic        bad_q, bad_d;
  logic        overrun_q, overrun_d;

  logic [31:0]         count_inc;
  lpmd_pkg::kind_e     kind;
  lpmd_pkg::verdict_e  verdict;

  assign count_inc = count_q + 32'd1;

  always_comb begin
    phase_d     = phase_q;
    ident_len_d = ident_len_q;
    plen_d      = plen_q;
    count_d     = count_q;
    bad_d       = bad_q;
    overrun_d   = overrun_q;
    kind        = lpmd_pkg::KIND_HEADER;
    verdict     = lpmd_pkg::VERDICT_OK;

    case (phase_q)
      lpmd_pkg::PH_LEN_HI: begin
        ident_len_d = {byte_i, 8'h00};
        phase_d     = lpmd_pkg::PH_LEN_LO;
      end
      lpmd_pkg::PH_LEN_LO: begin
        ident_len_d = ident_len_q | {8'h00, byte_i};
        count_d     = '0;
        plen_d      = '0;
        phase_d     = ((ident_len_q | {8'h00, byte_i}) != 16'd0) ?
                      lpmd_pkg::PH_IDENT : lpmd_pkg::PH_PLEN;
      end
      lpmd_pkg::PH_IDENT: begin
        kind = lpmd_pkg::KIND_IDENT;
        if (!lpmd_pkg::allowed_char(byte_i)) begin
          bad_d = 1'b1;
        end
        if (count_inc >= {16'd0, ident_len_q}) begin
          count_d = '0;
          phase_d = lpmd_pkg::PH_PLEN;
        end else begin
          count_d = count_inc;
        end
      end
      lpmd_pkg::PH_PLEN: begin
        plen_d = {plen_q[23:0], byte_i};
        if (count_inc >= 32'(lpmd_pkg::PlenBytes)) begin
          count_d = '0;
          phase_d = ({plen_q[23:0], byte_i} != 32'd0) ?
                    lpmd_pkg::PH_PAYLOAD : lpmd_pkg::PH_DONE;
        end else begin
          count_d = count_inc;
        end
      end
      lpmd_pkg::PH_PAYLOAD: begin
        kind    = lpmd_pkg::KIND_PAYLOAD;
        count_d = count_inc;
        if (count_inc == plen_q) begin
          phase_d = lpmd_pkg::PH_DONE;
        end
      end
      default: begin
        // bytes past the declared layout
        overrun_d = 1'b1;
      end
    endcase

    if (last_i) begin
      if (phase_d != lpmd_pkg::PH_DONE || overrun_d) begin
        verdict = lpmd_pkg::VERDICT_MISMATCH;
      end else if (bad_d) begin
        verdict = lpmd_pkg::VERDICT_BADCHAR;
      end
      phase_d     = lpmd_pkg::PH_LEN_HI;
      ident_len_d = '0;
      plen_d      = '0;
      count_d     = '0;
      bad_d       = 1'b0;
      overrun_d   = 1'b0;
    end
  end

  assign result_o.out_byte  = byte_i;
  assign result_o.byte_kind = kind;
  assign result_o.frame_end = last_i;
  assign result_o.verdict   = verdict;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= lpmd_pkg::PH_LEN_HI;
      ident_len_q <= '0;
      plen_q      <= '0;
      count_q     <= '0;
      bad_q       <= 1'b0;
      overrun_q   <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      ident_len_q <= ident_len_d;
      plen_q      <= plen_d;
      count_q     <= count_d;
      bad_q       <= bad_d;
      overrun_q   <= overrun_d;
    end
  end

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> phase_q == lpmd_pkg::PH_LEN_HI && !bad_q && !overrun_q)
    else $error("packet end did not restart the parser");

  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == lpmd_pkg::PH_PAYLOAD |-> plen_q != 32'd0 && count_q < plen_q)
    else $error("payload phase with count at or past the declared length");

  a_ident_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == lpmd_pkg::PH_IDENT |-> count_q < {16'd0, ident_len_q})
    else $error("identifier count at or past the declared length");

endmodule

`default_nettype wire

### rtl/length_prefixed_message_deframer.sv
// top level of the length-prefixed message deframer
`timescale 1ns / 1ps
`default_nettype none

// Takes one packet byte per transaction and returns one tagged result per byte:
// header (length bytes), identifier or payload, with a verdict on the byte that
// carries the end-of-packet mark (ok, bad identifier character, length mismatch).
// A packet is a 2-byte big-endian identifier length, the identifier, a 4-byte
// big-endian payload length and the payload. The block sustains one byte per
// clock while the result channel is ready; a result passes through the input
// register, then the result register. The rate is set by the parser registers,
// which take one compare and one 32-bit count update per byte. The parser
// restarts on the cycle after each end-of-packet byte with no idle gap.

module length_prefixed_message_deframer (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lpmd_in_if.sink    in_i,
  lpmd_out_if.source out_o
);

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       s1_move;

  logic              out_valid_q;
  lpmd_pkg::result_t out_res_q;
  lpmd_pkg::result_t res;

  assign s1_move  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q <= in_i.in_byte;
      s1_last_q <= in_i.in_last;
    end
  end

  lpmd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_move),
    .byte_i   (s1_byte_q),
    .last_i   (s1_last_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_byte  = out_res_q.out_byte;
  assign out_o.byte_kind = out_res_q.byte_kind;
  assign out_o.frame_end = out_res_q.frame_end;
  assign out_o.verdict   = out_res_q.verdict;

  a_verdict_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_res_q.frame_end |-> out_res_q.verdict == lpmd_pkg::VERDICT_OK)
    else $error("verdict set on a byte that does not end the packet");

  a_stalled_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_move |=> s1_valid_q && $stable(s1_byte_q) && $stable(s1_last_q))
    else $error("input register changed while its item waited");

  a_move_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> out_valid_q)
    else $error("item left the input register without reaching the result register");

endmodule

`default_nettype wire
